// File: rtl/sul_pkg.sv
package sul_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CFG_W    = 5;
	localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int VAL_W    = 32;
	localparam int CMD_W    = 2;

	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SHOW   = 2'd2;

	localparam logic KIND_REMOVED = 1'b0;
	localparam logic KIND_LISTED  = 1'b1;

	typedef logic [VAL_W-1:0] value_t;
	typedef logic [CNT_W-1:0] count_t;

endpackage

// File: rtl/sul_ram.sv
module sul_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/sorted_unique_list_top.sv
// Sorted unique list of signed 32-bit values.
// Input channel s_*: s_tuser carries the command (insert, remove, show),
// s_tdata the value. Output channel m_*: m_tuser is the kind (removal report
// or listed entry), m_tdata the value, m_tlast marks the last result of a
// command. cfg_* writes the capacity in use; it is always ready.
// All entries sit in one single-port-read RAM, and one comparator walks it
// one entry per cycle under a small sequencer; the block takes one command
// at a time and drops s_tready until the command is finished.
// With n stored entries and p the insert/remove position:
//   insert: search up to p, shift entries p..n-1 up one slot, write the value at p;
//   remove: search up to p, shift the entries above p down, then report once the output slot is free;
//   show:   lists all n entries, one entry per cycle while the receiver takes them.
// Inserts into a full list, unused commands and show of an empty list are taken in idle and do nothing.
// A stalled receiver holds the output register; the sequencer waits on it.
// Reset empties the list and sets the capacity in use to 16; the RAM keeps
// its contents, which are never read before being written.
module sorted_unique_list_top
	import sul_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // [31:0] value
	input  logic [1:0]       s_tuser,   // [1:0] cmd
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,   // [31:0] value_out
	output logic [0:0]       m_tuser,   // [0] kind
	output logic             m_tlast,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SEARCH = 3'd1;
	localparam logic [2:0] ST_SHUP   = 3'd2;
	localparam logic [2:0] ST_PUT    = 3'd3;
	localparam logic [2:0] ST_SHDN   = 3'd4;
	localparam logic [2:0] ST_REPORT = 3'd5;
	localparam logic [2:0] ST_LIST   = 3'd6;

	logic [2:0]       state_q, state_d;
	count_t           idx_q, idx_d, pos_q, pos_d, count_q, count_d;
	logic [CFG_W-1:0] cap_q;
	value_t           v_q;
	logic [CMD_W-1:0] cmd_q;

	logic             out_valid_q;
	value_t           out_data_q;
	logic             out_kind_q, out_last_q;
	logic             out_load, out_kind_d, out_last_d;
	value_t           out_data_d;
	logic             out_free;

	logic             we;
	logic [IDX_W-1:0] waddr;
	value_t           wdata, rdata;
	count_t           idx_inc, idx_dec;
	logic [CMP_W-1:0] cap_ext, eff_cap;
	logic             full, hit, above;

	sul_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_d[IDX_W-1:0]),
		.rdata (rdata)
	);

	assign cap_ext  = CMP_W'(cap_q);
	assign eff_cap  = (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
	assign full     = CMP_W'(count_q) >= eff_cap;
	assign idx_inc  = CNT_W'(idx_q + 1'b1);
	assign idx_dec  = CNT_W'(idx_q - 1'b1);
	assign hit      = (rdata == v_q);
	assign above    = $signed(rdata) > $signed(v_q);
	assign out_free = !out_valid_q || m_tready;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_kind_q;
	assign m_tlast   = out_last_q;

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		pos_d      = pos_q;
		count_d    = count_q;
		we         = 1'b0;
		waddr      = idx_q[IDX_W-1:0];
		wdata      = rdata;
		out_load   = 1'b0;
		out_kind_d = KIND_LISTED;
		out_data_d = rdata;
		out_last_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idx_d = '0;
				if (s_tvalid) begin
					case (s_tuser)
						CMD_INSERT: if (!full) state_d = ST_SEARCH;
						CMD_REMOVE: state_d = ST_SEARCH;
						CMD_SHOW:   if (count_q != '0) state_d = ST_LIST;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_SEARCH: begin
				if (idx_q == count_q) begin
					// end of list: insert appends, remove found nothing
					if (cmd_q == CMD_INSERT) begin
						pos_d   = idx_q;
						state_d = ST_PUT;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (hit) begin
					if (cmd_q == CMD_INSERT) begin
						state_d = ST_IDLE;
					end else begin
						idx_d   = idx_inc;
						state_d = ST_SHDN;
					end
				end else if (above && cmd_q == CMD_INSERT) begin
					pos_d   = idx_q;
					idx_d   = CNT_W'(count_q - 1'b1);
					state_d = ST_SHUP;
				end else if (above) begin
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_inc;
				end
			end
			ST_SHUP: begin
				// move entry up one slot, walk down to the insert position
				we    = 1'b1;
				waddr = idx_inc[IDX_W-1:0];
				if (idx_q == pos_q) begin
					state_d = ST_PUT;
				end else begin
					idx_d = idx_dec;
				end
			end
			ST_PUT: begin
				we      = 1'b1;
				waddr   = pos_q[IDX_W-1:0];
				wdata   = v_q;
				count_d = CNT_W'(count_q + 1'b1);
				state_d = ST_IDLE;
			end
			ST_SHDN: begin
				// close the gap: move entry down one slot
				if (idx_q == count_q) begin
					count_d = idx_dec;
					state_d = ST_REPORT;
				end else begin
					we    = 1'b1;
					waddr = idx_dec[IDX_W-1:0];
					idx_d = idx_inc;
				end
			end
			ST_REPORT: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_kind_d = KIND_REMOVED;
					out_data_d = v_q;
					out_last_d = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_LIST: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_last_d = (idx_inc == count_q);
					if (idx_inc == count_q) begin
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_inc;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			pos_q       <= '0;
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			pos_q   <= pos_d;
			count_q <= count_d;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			v_q   <= s_tdata;
			cmd_q <= s_tuser;
		end
		if (out_load) begin
			out_data_q <= out_data_d;
			out_kind_q <= out_kind_d;
			out_last_q <= out_last_d;
		end
	end

endmodule
